// File: src/uart_rbe_pkg.sv
// Shared opcode and status codes for the UART ring buffer engine.
`timescale 1ns / 1ps
`default_nettype none

package uart_rbe_pkg;

   typedef enum logic [1:0] {
      OP_HOST_WRITE = 2'd0,
      OP_HOST_READ  = 2'd1,
      OP_LINE_RX    = 2'd2,
      OP_TX_READY   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_RX_EMPTY = 3'd1,
      ST_TX_FULL  = 3'd2,
      ST_RX_DROP  = 3'd3,
      ST_IGNORED  = 3'd4
   } status_type;

   localparam int unsigned AVAIL_MAX = 63;

endpackage : uart_rbe_pkg

`default_nettype wire

// File: src/uart_ring_buffer_engine_unit.sv
// UART ring buffer engine: transmit and receive rings in synchronous memories.
// The response strobe is registered and rises in the cycle after the request is accepted.
// Throughput: one request per cycle; each request touches at most one memory entry of one ring
// and its pointers, so busy stays low and pointers update at the accept edge.
// Reset clears pointers and flags; ring memories are undefined until written.
// The receiver cannot stall: each response is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module uart_ring_buffer_engine_unit
   import uart_rbe_pkg::*;
#(
   parameter int unsigned TX_DEPTH = 64,
   parameter int unsigned RX_DEPTH = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_line_ready,
   output logic            rsp_valid,
   output logic [2:0]      rsp_status,
   output logic [7:0]      rsp_read_byte,
   output logic            rsp_line_send,
   output logic [7:0]      rsp_line_byte,
   output logic [5:0]      rsp_rx_available,
   output logic            rsp_drain_active,
   output logic            rsp_host_wrote
);

   localparam int unsigned TXW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int unsigned RXW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int unsigned CW  = RXW + 1;

   logic [7:0] tx_mem [TX_DEPTH];
   logic [7:0] rx_mem [RX_DEPTH];

   logic [TXW-1:0] tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in;
   logic [RXW-1:0] rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in;
   logic           drain_ff, drain_in;
   logic           written_ff, written_in;

   logic [TXW-1:0] tx_wp_nx, tx_rp_nx;
   logic [RXW-1:0] rx_wp_nx, rx_rp_nx;
   logic           accept;
   logic           tx_we, tx_re, rx_we, rx_re, direct;
   status_type     status_in;
   opcode_type     op;

   logic           rsp_valid_ff;
   status_type     rsp_status_ff;
   logic           rsp_tx_pop_ff, rsp_rx_pop_ff, rsp_direct_ff;
   logic [7:0]     rsp_data_ff;
   logic [7:0]     tx_rdata_ff, rx_rdata_ff;
   logic [CW-1:0]  rx_diff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign op     = opcode_type'(req_opcode);

   assign tx_wp_nx = (tx_wp_ff == TXW'(TX_DEPTH - 1)) ? '0 : tx_wp_ff + TXW'(1);
   assign tx_rp_nx = (tx_rp_ff == TXW'(TX_DEPTH - 1)) ? '0 : tx_rp_ff + TXW'(1);
   assign rx_wp_nx = (rx_wp_ff == RXW'(RX_DEPTH - 1)) ? '0 : rx_wp_ff + RXW'(1);
   assign rx_rp_nx = (rx_rp_ff == RXW'(RX_DEPTH - 1)) ? '0 : rx_rp_ff + RXW'(1);

   always_comb begin
      tx_wp_in   = tx_wp_ff;
      tx_rp_in   = tx_rp_ff;
      rx_wp_in   = rx_wp_ff;
      rx_rp_in   = rx_rp_ff;
      drain_in   = drain_ff;
      written_in = written_ff;
      tx_we      = 1'b0;
      tx_re      = 1'b0;
      rx_we      = 1'b0;
      rx_re      = 1'b0;
      direct     = 1'b0;
      status_in  = ST_DONE;
      if (accept) begin
         unique case (op)
            OP_HOST_WRITE: begin
               written_in = 1'b1;
               if (tx_wp_ff == tx_rp_ff && !drain_ff && req_line_ready) begin
                  direct = 1'b1;
               end else if (tx_wp_nx == tx_rp_ff) begin
                  status_in = ST_TX_FULL;
               end else begin
                  tx_we    = 1'b1;
                  tx_wp_in = tx_wp_nx;
                  drain_in = 1'b1;
               end
            end
            OP_HOST_READ: begin
               if (rx_wp_ff == rx_rp_ff) begin
                  status_in = ST_RX_EMPTY;
               end else begin
                  rx_re    = 1'b1;
                  rx_rp_in = rx_rp_nx;
               end
            end
            OP_LINE_RX: begin
               if (rx_wp_nx == rx_rp_ff) begin
                  status_in = ST_RX_DROP;
               end else begin
                  rx_we    = 1'b1;
                  rx_wp_in = rx_wp_nx;
               end
            end
            OP_TX_READY: begin
               if (!drain_ff) begin
                  status_in = ST_IGNORED;
               end else if (tx_wp_ff == tx_rp_ff) begin
                  drain_in  = 1'b0;
                  status_in = ST_IGNORED;
               end else begin
                  tx_re    = 1'b1;
                  tx_rp_in = tx_rp_nx;
                  if (tx_wp_ff == tx_rp_nx) begin
                     drain_in = 1'b0;
                  end
               end
            end
            default: begin
               status_in = ST_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_wp_ff] <= req_data_byte;
      end
      if (tx_re) begin
         tx_rdata_ff <= tx_mem[tx_rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_wp_ff] <= req_data_byte;
      end
      if (rx_re) begin
         rx_rdata_ff <= rx_mem[rx_rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_wp_ff     <= '0;
         tx_rp_ff     <= '0;
         rx_wp_ff     <= '0;
         rx_rp_ff     <= '0;
         drain_ff     <= 1'b0;
         written_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tx_wp_ff     <= tx_wp_in;
         tx_rp_ff     <= tx_rp_in;
         rx_wp_ff     <= rx_wp_in;
         rx_rp_ff     <= rx_rp_in;
         drain_ff     <= drain_in;
         written_ff   <= written_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_tx_pop_ff <= tx_re;
         rsp_rx_pop_ff <= rx_re;
         rsp_direct_ff <= direct;
         rsp_data_ff   <= req_data_byte;
      end
   end

   assign rx_diff = (rx_wp_ff >= rx_rp_ff)
                  ? CW'(rx_wp_ff) - CW'(rx_rp_ff)
                  : CW'(rx_wp_ff) + CW'(RX_DEPTH) - CW'(rx_rp_ff);

   always_comb begin
      if (32'(rx_diff) > 32'(AVAIL_MAX)) begin
         rsp_rx_available = 6'(AVAIL_MAX);
      end else begin
         rsp_rx_available = 6'(rx_diff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_read_byte    = rsp_rx_pop_ff ? rx_rdata_ff : 8'd0;
   assign rsp_line_send    = rsp_tx_pop_ff || rsp_direct_ff;
   assign rsp_line_byte    = rsp_tx_pop_ff ? tx_rdata_ff
                           : (rsp_direct_ff ? rsp_data_ff : 8'd0);
   assign rsp_drain_active = drain_ff;
   assign rsp_host_wrote   = written_ff;

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid)
      else $error("request accepted without response");

   a_send_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_send |-> rsp_status == ST_DONE)
      else $error("line send with non-done status");

   a_ignored_no_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_IGNORED |-> !rsp_drain_active)
      else $error("ignored transmit ready left draining armed");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_RX_EMPTY |-> rsp_rx_available == 6'd0)
      else $error("receive empty reported with bytes waiting");

   a_write_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_TX_FULL || rsp_drain_active) |-> rsp_host_wrote)
      else $error("transmit activity without host write flag");

endmodule : uart_ring_buffer_engine_unit

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the UART transmit/receive ring buffer engine.
`timescale 1ns / 1ps

module testbench;
   import uart_rbe_pkg::*;

   localparam int unsigned RING_DEPTH  = 64;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 4;

   typedef struct {
      status_type  status;
      logic [7:0]  read_byte;
      logic        line_send;
      logic [7:0]  line_byte;
      logic [5:0]  rx_available;
      logic        drain_active;
      logic        host_wrote;
   } uart_response_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_opcode;
   logic [7:0] req_data_byte;
   logic       req_line_ready;
   logic       rsp_valid;
   logic [2:0] rsp_status;
   logic [7:0] rsp_read_byte;
   logic       rsp_line_send;
   logic [7:0] rsp_line_byte;
   logic [5:0] rsp_rx_available;
   logic       rsp_drain_active;
   logic       rsp_host_wrote;

   logic [7:0]  tx_ring [RING_DEPTH];
   logic [7:0]  rx_ring [RING_DEPTH];
   int unsigned tx_head;
   int unsigned tx_tail;
   int unsigned rx_head;
   int unsigned rx_tail;
   logic        drain_armed;
   logic        host_has_written;

   uart_response_type pending_responses[$];
   int unsigned       error_count;
   int unsigned       cycle_count;
   int unsigned       requests_sent;
   int unsigned       idle_pct;

   uart_ring_buffer_engine_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_line_ready   (req_line_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_line_send    (rsp_line_send),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_rx_available (rsp_rx_available),
      .rsp_drain_active (rsp_drain_active),
      .rsp_host_wrote   (rsp_host_wrote)
   );

   always #4 clock = ~clock;

   function automatic uart_response_type predict_response(opcode_type op, logic [7:0] data,
                                                          logic ready);
      uart_response_type r;
      int unsigned       nxt;
      r.status    = ST_DONE;
      r.read_byte = 8'd0;
      r.line_send = 1'b0;
      r.line_byte = 8'd0;
      case (op)
         OP_HOST_WRITE: begin
            host_has_written = 1'b1;
            if (tx_head == tx_tail && !drain_armed && ready) begin
               r.line_send = 1'b1;
               r.line_byte = data;
            end else begin
               nxt = (tx_head + 1) % RING_DEPTH;
               if (nxt == tx_tail) begin
                  r.status = ST_TX_FULL;
               end else begin
                  tx_ring[tx_head] = data;
                  tx_head = nxt;
                  drain_armed = 1'b1;
               end
            end
         end
         OP_HOST_READ: begin
            if (rx_head == rx_tail) begin
               r.status = ST_RX_EMPTY;
            end else begin
               r.read_byte = rx_ring[rx_tail];
               rx_tail = (rx_tail + 1) % RING_DEPTH;
            end
         end
         OP_LINE_RX: begin
            nxt = (rx_head + 1) % RING_DEPTH;
            if (nxt == rx_tail) begin
               r.status = ST_RX_DROP;
            end else begin
               rx_ring[rx_head] = data;
               rx_head = nxt;
            end
         end
         default: begin
            if (!drain_armed) begin
               r.status = ST_IGNORED;
            end else if (tx_head == tx_tail) begin
               drain_armed = 1'b0;
               r.status = ST_IGNORED;
            end else begin
               r.line_send = 1'b1;
               r.line_byte = tx_ring[tx_tail];
               tx_tail = (tx_tail + 1) % RING_DEPTH;
               if (tx_head == tx_tail) drain_armed = 1'b0;
            end
         end
      endcase
      r.rx_available = 6'((RING_DEPTH + rx_head - rx_tail) % RING_DEPTH);
      r.drain_active = drain_armed;
      r.host_wrote   = host_has_written;
      return r;
   endfunction

   always @(posedge clock) begin
      uart_response_type exp_rsp;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else if (!reset) begin
         if (start === 1'b1 && busy === 1'b0)
            pending_responses.push_back(predict_response(opcode_type'(req_opcode),
                                                         req_data_byte, req_line_ready));
         if (rsp_valid === 1'b1) begin
            if (pending_responses.size() == 0) begin
               $error("unexpected response: status %0d", rsp_status);
               error_count++;
            end else begin
               exp_rsp = pending_responses.pop_front();
               if (rsp_status !== exp_rsp.status) begin
                  $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_status);
                  error_count++;
               end
               if (rsp_read_byte !== exp_rsp.read_byte) begin
                  $error("read_byte: expected %0h, actual %0h", exp_rsp.read_byte,
                         rsp_read_byte);
                  error_count++;
               end
               if (rsp_line_send !== exp_rsp.line_send) begin
                  $error("line_send: expected %0d, actual %0d", exp_rsp.line_send,
                         rsp_line_send);
                  error_count++;
               end
               if (rsp_line_byte !== exp_rsp.line_byte) begin
                  $error("line_byte: expected %0h, actual %0h", exp_rsp.line_byte,
                         rsp_line_byte);
                  error_count++;
               end
               if (rsp_rx_available !== exp_rsp.rx_available) begin
                  $error("rx_available: expected %0d, actual %0d", exp_rsp.rx_available,
                         rsp_rx_available);
                  error_count++;
               end
               if (rsp_drain_active !== exp_rsp.drain_active) begin
                  $error("drain_active: expected %0d, actual %0d", exp_rsp.drain_active,
                         rsp_drain_active);
                  error_count++;
               end
               if (rsp_host_wrote !== exp_rsp.host_wrote) begin
                  $error("host_wrote: expected %0d, actual %0d", exp_rsp.host_wrote,
                         rsp_host_wrote);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic send_request(opcode_type op, logic [7:0] data, logic ready);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_data_byte  <= data;
      req_line_ready <= ready;
      do @(posedge clock); while (busy !== 1'b0);
      requests_sent++;
   endtask

   task automatic send_random_request();
      send_request(opcode_type'($urandom_range(3)), 8'($urandom), 1'($urandom));
   endtask

   task automatic wait_until_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_request(OP_HOST_READ, 8'hFF, 1'b1);
      send_request(OP_TX_READY, 8'hFF, 1'b1);
      send_request(OP_HOST_WRITE, 8'h00, 1'b1);
      send_request(OP_HOST_WRITE, 8'hFF, 1'b1);
      send_request(OP_HOST_WRITE, 8'hA5, 1'b0);
      send_request(OP_HOST_WRITE, 8'h5A, 1'b1);
      send_request(OP_HOST_WRITE, 8'hFF, 1'b1);
      send_request(OP_TX_READY, 8'h00, 1'b0);
      send_request(OP_TX_READY, 8'h00, 1'b1);
      send_request(OP_TX_READY, 8'h00, 1'b0);
      send_request(OP_TX_READY, 8'h00, 1'b1);
      send_request(OP_HOST_WRITE, 8'h3C, 1'b1);
      send_request(OP_LINE_RX, 8'hFF, 1'b0);
      send_request(OP_LINE_RX, 8'h00, 1'b1);
      send_request(OP_LINE_RX, 8'h81, 1'b0);
      send_request(OP_HOST_READ, 8'h00, 1'b0);
      send_request(OP_HOST_READ, 8'h00, 1'b1);
      send_request(OP_HOST_READ, 8'h00, 1'b0);
      send_request(OP_HOST_READ, 8'h00, 1'b1);
   endtask

   task automatic transmit_burst();
      int unsigned n;
      n = $urandom_range(1, 70);
      repeat (n) send_request(OP_HOST_WRITE, 8'($urandom), 1'($urandom));
      n = $urandom_range(1, 70);
      repeat (n) send_request(OP_TX_READY, 8'($urandom), 1'($urandom));
   endtask

   task automatic receive_burst();
      int unsigned n;
      n = $urandom_range(1, 70);
      repeat (n) send_request(OP_LINE_RX, 8'($urandom), 1'($urandom));
      n = $urandom_range(1, 70);
      repeat (n) send_request(OP_HOST_READ, 8'($urandom), 1'($urandom));
   endtask

   task automatic test_transmit_ring(int unsigned count);
      int unsigned target;
      target = requests_sent + count;
      while (requests_sent < target) begin
         if ($urandom_range(4) == 0) send_random_request();
         else transmit_burst();
      end
   endtask

   task automatic test_receive_ring(int unsigned count);
      int unsigned target;
      target = requests_sent + count;
      while (requests_sent < target) begin
         if ($urandom_range(4) == 0) send_random_request();
         else receive_burst();
      end
   endtask

   task automatic test_mixed_traffic(int unsigned count);
      int unsigned target;
      target = requests_sent + count;
      while (requests_sent < target) begin
         case ($urandom_range(9))
            0, 1, 2: transmit_burst();
            3, 4, 5: receive_burst();
            default: repeat ($urandom_range(1, 20)) send_random_request();
         endcase
      end
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_opcode     <= OP_HOST_WRITE;
      req_data_byte  <= 8'd0;
      req_line_ready <= 1'b0;
      cycle_count    = 0;
      error_count    = 0;
      requests_sent  = 0;
      tx_head = 0;
      tx_tail = 0;
      rx_head = 0;
      rx_tail = 0;
      drain_armed      = 1'b0;
      host_has_written = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 35;
      test_directed_cases();
      test_transmit_ring(275);
      test_receive_ring(275);
      wait_until_quiet();
      idle_pct = 55;
      test_mixed_traffic(550);
      wait_until_quiet();
      idle_pct = 0;
      test_mixed_traffic(550);

      wait_until_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_responses.size() != 0) begin
         $error("responses missing: %0d", pending_responses.size());
         error_count++;
      end
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
